@@ hdl/hlfc_pkg.sv @@
// ----------------------------------------------------------------------------
// hlfc_pkg
// Shared types and codes of the humidity / light fan controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hlfc_pkg;

  // humidity threshold limit, larger modes select light-timer control
  localparam logic [7:0] MODE_LIMIT = 8'd100;

  // register reset values
  localparam logic [7:0] RST_LIGHT_THRESHOLD = 8'd200;
  localparam logic [7:0] RST_PULSE_MAX       = 8'd5;
  localparam logic [7:0] RST_MENU_PULSES     = 8'd5;
  localparam logic [7:0] RST_ACT_TIMEOUT     = 8'd10;
  localparam logic [7:0] RST_MENU_TIMEOUT    = 8'd10;
  localparam logic [7:0] RST_HUM_PERIOD      = 8'd30;
  localparam logic [7:0] RST_LIGHT_DEBOUNCE  = 8'd15;
  localparam logic [7:0] RST_INITIAL_MODE    = 8'd50;

  // register indexes
  localparam logic [2:0] REG_LIGHT_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_PULSE_MAX       = 3'd1;
  localparam logic [2:0] REG_MENU_PULSES     = 3'd2;
  localparam logic [2:0] REG_ACT_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_MENU_TIMEOUT    = 3'd4;
  localparam logic [2:0] REG_HUM_PERIOD      = 3'd5;
  localparam logic [2:0] REG_LIGHT_DEBOUNCE  = 3'd6;
  localparam logic [2:0] REG_INITIAL_MODE    = 3'd7;

  // light events
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ON    = 2'd1;
  localparam logic [1:0] EV_PULSE = 2'd2;
  localparam logic [1:0] EV_OFF   = 2'd3;

  // light classifier phases
  localparam logic [1:0] LP_OFF   = 2'd0;
  localparam logic [1:0] LP_COUNT = 2'd1;
  localparam logic [1:0] LP_ON    = 2'd2;

  // menu phases
  localparam logic [1:0] MP_IDLE = 2'd0;
  localparam logic [1:0] MP_ACT  = 2'd1;
  localparam logic [1:0] MP_MODE = 2'd2;

  // timer mode phases
  localparam logic [1:0] TP_OFF = 2'd0;
  localparam logic [1:0] TP_DEB = 2'd1;
  localparam logic [1:0] TP_ON  = 2'd2;

  typedef struct packed {
    logic [7:0] pulse_max_secs;
    logic [7:0] menu_pulses;
    logic [7:0] activation_timeout_secs;
    logic [7:0] menu_timeout_secs;
    logic [7:0] humidity_period_secs;
    logic [7:0] light_debounce_secs;
  } hlfc_cfg_t;

  typedef struct packed {
    logic       fan_on;
    logic       indicator_led;
    logic       store_write;
    logic [7:0] store_value;
  } hlfc_res_t;

endpackage

`default_nettype wire

@@ hdl/hlfc_light_classifier.sv @@
// ----------------------------------------------------------------------------
// hlfc_light_classifier
// Turns the lit / dark decision of each pass into light on, pulse and off
// events, tracking how long the light has been on.
// ----------------------------------------------------------------------------
`default_nettype none

module hlfc_light_classifier
  import hlfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] now,
  input  wire logic       lit,
  input  wire logic [7:0] pulse_max_secs,
  output logic      [1:0] ev
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] start_r, start_nxt;
  logic [7:0] on_time;

  assign on_time = now - start_r;

  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    ev        = EV_NONE;
    unique case (phase_r)
      LP_COUNT: begin
        if (lit) begin
          if (on_time > pulse_max_secs) begin
            phase_nxt = LP_ON;
            ev        = EV_ON;
          end
        end else begin
          phase_nxt = LP_OFF;
          ev        = EV_PULSE;
        end
      end
      LP_ON: begin
        if (!lit) begin
          phase_nxt = LP_OFF;
          ev        = EV_OFF;
        end
      end
      default: begin
        // unused code falls back to off
        phase_nxt = LP_OFF;
        if (lit) begin
          phase_nxt = LP_COUNT;
          start_nxt = now;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= LP_OFF;
      start_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/hlfc_ctrl_core.sv @@
// ----------------------------------------------------------------------------
// hlfc_ctrl_core
// Fan control (humidity threshold or light timer) and the pulse-driven
// configuration menu, one pass per step.
// ----------------------------------------------------------------------------
`default_nettype none

module hlfc_ctrl_core
  import hlfc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic [7:0]       now,
  input  wire logic signed [7:0] hum,
  input  wire logic [1:0]       ev,
  input  wire hlfc_cfg_t        cfg,
  input  wire logic             mode_load,
  input  wire logic [7:0]       mode_value,
  output hlfc_res_t             res,
  output logic [7:0]            active_mode
);

  logic [1:0] menu_phase_r, menu_phase_nxt;
  logic [1:0] tmode_phase_r, tmode_phase_nxt;
  logic [7:0] pulse_count_r, pulse_count_nxt;
  logic [7:0] period_start_r, period_start_nxt;
  logic [7:0] menu_start_r, menu_start_nxt;
  logic [7:0] mode_r, mode_nxt;
  logic       fan_r, fan_nxt;
  logic       led_r, led_nxt;
  logic       store;
  logic [7:0] store_val;
  logic [7:0] period_age;
  logic [7:0] menu_age;
  logic [7:0] pulse_inc;

  assign period_age  = now - period_start_r;
  assign menu_age    = now - menu_start_r;
  assign pulse_inc   = pulse_count_r + 8'd1;
  assign active_mode = mode_r;

  always_comb begin
    menu_phase_nxt   = menu_phase_r;
    tmode_phase_nxt  = tmode_phase_r;
    pulse_count_nxt  = pulse_count_r;
    period_start_nxt = period_start_r;
    menu_start_nxt   = menu_start_r;
    mode_nxt         = mode_r;
    fan_nxt          = fan_r;
    led_nxt          = led_r;
    store            = 1'b0;
    store_val        = '0;

    // fan control is frozen while the menu is open
    if (menu_phase_r == MP_IDLE) begin
      if (mode_r <= MODE_LIMIT) begin
        if (period_age > cfg.humidity_period_secs) begin
          // failed read keeps the fan but restarts the period
          if (hum > 8'sd0) begin
            fan_nxt = ($unsigned(hum) >= mode_r);
          end
          period_start_nxt = now;
        end
      end else begin
        unique case (tmode_phase_r)
          TP_DEB: begin
            if (ev == EV_OFF) begin
              tmode_phase_nxt = TP_OFF;
            end else if (period_age > cfg.light_debounce_secs) begin
              tmode_phase_nxt = TP_ON;
              fan_nxt         = 1'b1;
            end
          end
          TP_ON: begin
            if (ev == EV_OFF) begin
              tmode_phase_nxt = TP_OFF;
              fan_nxt         = 1'b0;
            end
          end
          default: begin
            tmode_phase_nxt = TP_OFF;
            if (ev == EV_ON) begin
              period_start_nxt = now;
              tmode_phase_nxt  = TP_DEB;
            end
          end
        endcase
      end
    end

    unique case (menu_phase_r)
      MP_IDLE: begin
        if (ev == EV_PULSE) begin
          pulse_count_nxt = 8'd1;
          menu_phase_nxt  = MP_ACT;
          menu_start_nxt  = now;
        end
      end
      MP_ACT: begin
        if (menu_age > cfg.activation_timeout_secs) begin
          menu_phase_nxt = MP_IDLE;
          led_nxt        = 1'b0;
        end else if (ev == EV_PULSE) begin
          menu_start_nxt  = now;
          pulse_count_nxt = pulse_inc;
          if (pulse_inc >= cfg.menu_pulses) begin
            led_nxt         = 1'b1;
            menu_phase_nxt  = MP_MODE;
            pulse_count_nxt = '0;
            fan_nxt         = 1'b0;
          end
        end
      end
      MP_MODE: begin
        if (menu_age > cfg.menu_timeout_secs) begin
          menu_phase_nxt = MP_IDLE;
          if (pulse_count_r != 8'd0) begin
            // count times ten, wrapping at 8 bits
            mode_nxt        = (pulse_count_r << 3) + (pulse_count_r << 1);
            led_nxt         = 1'b0;
            pulse_count_nxt = '0;
            store           = 1'b1;
            store_val       = mode_nxt;
          end
        end
        if (ev == EV_PULSE) begin
          menu_start_nxt  = now;
          pulse_count_nxt = pulse_count_nxt + 8'd1;
        end
      end
      default: begin
        menu_phase_nxt = MP_IDLE;
      end
    endcase

    res.fan_on        = fan_nxt;
    res.indicator_led = led_nxt;
    res.store_write   = store;
    res.store_value   = store_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_phase_r   <= MP_IDLE;
      tmode_phase_r  <= TP_OFF;
      pulse_count_r  <= '0;
      period_start_r <= '0;
      menu_start_r   <= '0;
      mode_r         <= RST_INITIAL_MODE;
      fan_r          <= 1'b0;
      led_r          <= 1'b0;
    end else begin
      if (step_en) begin
        menu_phase_r   <= menu_phase_nxt;
        tmode_phase_r  <= tmode_phase_nxt;
        pulse_count_r  <= pulse_count_nxt;
        period_start_r <= period_start_nxt;
        menu_start_r   <= menu_start_nxt;
        fan_r          <= fan_nxt;
        led_r          <= led_nxt;
      end
      // writing the initial mode reloads the active mode
      if (mode_load) begin
        mode_r <= mode_value;
      end else if (step_en) begin
        mode_r <= mode_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/humidity_light_fan_controller.sv @@
// ----------------------------------------------------------------------------
// humidity_light_fan_controller
// Fan controller driven by humidity readings and light switch pulses.
// ----------------------------------------------------------------------------
// Takes one control pass per clock cycle unless the output stalls, and
// returns one result per pass. A pass is latched in an input register,
// evaluated combinationally by the light classifier and the control core,
// and the result is held in an output register. Throughput is one beat per
// cycle while out_ready stays high; a stalled output holds one result plus
// one pending input.
// Configuration registers are written through cfg_we / cfg_index /
// cfg_wdata; writing initial_mode also loads the active mode.
`default_nettype none

module humidity_light_fan_controller
  import hlfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_now_seconds,
  input  wire logic [7:0]        in_light_sample,
  input  wire logic signed [7:0] in_humidity_reading,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_fan_on,
  output logic                   out_indicator_led,
  output logic [1:0]             out_light_code,
  output logic                   out_store_write,
  output logic [7:0]             out_store_value,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [7:0]        cfg_wdata
);

  logic              s1_valid_r;
  logic [7:0]        s1_now_r;
  logic [7:0]        s1_sample_r;
  logic signed [7:0] s1_hum_r;
  logic              s1_adv;
  logic [7:0]        light_threshold_r;
  hlfc_cfg_t         cfg_r;
  logic [1:0]        ev;
  hlfc_res_t         res;
  logic              mode_load;
  logic [7:0]        active_mode;

  assign s1_adv   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_threshold_r             <= RST_LIGHT_THRESHOLD;
      cfg_r.pulse_max_secs          <= RST_PULSE_MAX;
      cfg_r.menu_pulses             <= RST_MENU_PULSES;
      cfg_r.activation_timeout_secs <= RST_ACT_TIMEOUT;
      cfg_r.menu_timeout_secs       <= RST_MENU_TIMEOUT;
      cfg_r.humidity_period_secs    <= RST_HUM_PERIOD;
      cfg_r.light_debounce_secs     <= RST_LIGHT_DEBOUNCE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_THRESHOLD: light_threshold_r             <= cfg_wdata;
        REG_PULSE_MAX:       cfg_r.pulse_max_secs          <= cfg_wdata;
        REG_MENU_PULSES:     cfg_r.menu_pulses             <= cfg_wdata;
        REG_ACT_TIMEOUT:     cfg_r.activation_timeout_secs <= cfg_wdata;
        REG_MENU_TIMEOUT:    cfg_r.menu_timeout_secs       <= cfg_wdata;
        REG_HUM_PERIOD:      cfg_r.humidity_period_secs    <= cfg_wdata;
        REG_LIGHT_DEBOUNCE:  cfg_r.light_debounce_secs     <= cfg_wdata;
        // initial mode goes straight into the active mode of the core
        default: ;
      endcase
    end
  end

  assign mode_load = cfg_we && (cfg_index == REG_INITIAL_MODE);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_now_r    <= in_now_seconds;
      s1_sample_r <= in_light_sample;
      s1_hum_r    <= in_humidity_reading;
    end
  end

  hlfc_light_classifier u_light (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (s1_adv),
    .now            (s1_now_r),
    .lit            (s1_sample_r < light_threshold_r),
    .pulse_max_secs (cfg_r.pulse_max_secs),
    .ev             (ev)
  );

  hlfc_ctrl_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_adv),
    .now         (s1_now_r),
    .hum         (s1_hum_r),
    .ev          (ev),
    .cfg         (cfg_r),
    .mode_load   (mode_load),
    .mode_value  (cfg_wdata),
    .res         (res),
    .active_mode (active_mode)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_fan_on        <= res.fan_on;
      out_indicator_led <= res.indicator_led;
      out_light_code    <= ev;
      out_store_write   <= res.store_write;
      out_store_value   <= res.store_value;
    end
  end

`ifndef SYNTHESIS
  // a stored mode always closes the menu lamp
  a_store_clears_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_write |-> !out_indicator_led)
    else $error("store beat with indicator lamp lit");

  // the stored value becomes the active mode
  a_store_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res.store_write && !mode_load |=> active_mode == $past(res.store_value))
    else $error("active mode differs from stored value");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
